// ----- hdl/one_shot_timer_table_assert.svh -----
// Assertion macros for the timer table.
`ifndef ONE_SHOT_TIMER_TABLE_ASSERT_SVH
`define ONE_SHOT_TIMER_TABLE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define OSTT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define OSTT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- hdl/ostt_pkg.sv -----
package ostt_pkg;

   localparam int SLOT_COUNT  = 8;
   localparam int MAX_RESULTS = 8;
   localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int REP_W       = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_W      = 3;

   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_REGISTER   = 2'd1;
   localparam logic [1:0] OP_UNREGISTER = 2'd2;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_FIRE   = 2'd1;
   localparam logic [1:0] KIND_QUIET  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [7:0]  owner;
      logic [15:0] limit;
      logic [15:0] count;
   } slot_entry_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [SLOT_W-1:0] slot;
      logic [7:0]        fired_id;
      logic [1:0]        status;
   } row_type;

   // reported slot number: low bits of the index
   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// ----- hdl/ostt_if.sv -----
interface ostt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [7:0]  timer_id;
   logic [15:0] delay_ticks;

   modport source (output valid, operation, timer_id, delay_ticks, input ready);
   modport sink   (input valid, operation, timer_id, delay_ticks, output ready);
endinterface

interface ostt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [2:0] slot;
   logic [7:0] fired_id;
   logic [1:0] status;
   logic       last;

   modport source (output valid, kind, slot, fired_id, status, last, input ready);
   modport sink   (input valid, kind, slot, fired_id, status, last, output ready);
endinterface

// ----- hdl/one_shot_timer_table.sv -----
// Channel | Dir | Handshake         | Item
// req     | in  | req.valid/ready   | operation, timer_id, delay_ticks
// rsp     | out | rsp.valid/ready   | kind, slot, fired_id, status, last
//
// Register: the free slot is found from the busy flops.
// Tick and unregister: one slot per cycle through the slot RAM read port while the
// walk is not stalled (unregister ends at the first match).
// Several fire rows in one tick stall the walk while the output register is full.
// Reset clears all busy marks at once; the RAM itself is not cleared.
// One item at a time; a new item is taken once the last row is in the output register.
`include "one_shot_timer_table_assert.svh"

module one_shot_timer_table (
   input logic        clock,
   input logic        reset,
   ostt_req_if.sink   req,
   ostt_rsp_if.source rsp
);
   import ostt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_type;

   state_type            state_ff, state_in;
   logic [SLOT_COUNT-1:0] busy_ff, busy_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [REP_W-1:0]     rep_ff, rep_in;
   logic [1:0]           op_ff, op_in;
   logic [7:0]           id_ff, id_in;
   row_type              pend_ff, pend_in;
   row_type              rsp_row_ff, rsp_row_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   slot_entry_type       wr_data;
   logic [IDX_W-1:0]     rd_addr;
   slot_entry_type       rd_data;

   logic                 accept;
   logic                 out_free;
   logic                 free_found;
   logic [IDX_W-1:0]     free_idx;
   logic                 cur_busy;
   logic [15:0]          cnt_next;
   logic                 hit_fire;
   logic                 hit_unreg;
   logic                 last_idx;
   logic                 advance;
   logic                 can_report;

   ostt_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req.ready    = (state_ff == S_IDLE);
   assign accept       = req.valid && req.ready;
   assign out_free     = !rsp_valid_ff || rsp.ready;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.kind     = rsp_row_ff.kind;
   assign rsp.slot     = rsp_row_ff.slot;
   assign rsp.fired_id = rsp_row_ff.fired_id;
   assign rsp.status   = rsp_row_ff.status;
   assign rsp.last     = rsp_last_ff;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign cur_busy   = busy_ff[idx_ff];
   assign cnt_next   = rd_data.count + 16'd1;
   assign hit_fire   = cur_busy && (cnt_next == rd_data.limit);
   assign hit_unreg  = cur_busy && (rd_data.owner == id_ff);
   assign last_idx   = (idx_ff == IDX_W'(SLOT_COUNT - 1));
   assign can_report = (rep_ff < REP_W'(MAX_RESULTS));

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rep_in       = rep_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      pend_in      = pend_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;
      rd_addr      = '0;
      advance      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req.operation;
               id_in  = req.timer_id;
               idx_in = '0;
               rep_in = '0;
               case (req.operation)
                  OP_REGISTER: begin
                     pend_in.kind     = KIND_STATUS;
                     pend_in.slot     = free_found ? slot_of(free_idx) : '0;
                     pend_in.fired_id = 8'd0;
                     pend_in.status   = free_found ? ST_OK : ST_FULL;
                     if (free_found) begin
                        wr_en             = 1'b1;
                        wr_addr           = free_idx;
                        wr_data.owner     = req.timer_id;
                        wr_data.limit     = req.delay_ticks;
                        wr_data.count     = 16'd0;
                        busy_in[free_idx] = 1'b1;
                     end
                     state_in = S_FINISH;
                  end
                  OP_UNREGISTER: begin
                     pend_in.kind     = KIND_STATUS;
                     pend_in.slot     = '0;
                     pend_in.fired_id = 8'd0;
                     pend_in.status   = ST_NOT_FOUND;
                     state_in         = S_SCAN;
                  end
                  OP_TICK: begin
                     pend_in.kind     = KIND_QUIET;
                     pend_in.slot     = '0;
                     pend_in.fired_id = 8'd0;
                     pend_in.status   = ST_OK;
                     state_in         = S_SCAN;
                  end
                  default: ;
               endcase
            end
         end

         S_SCAN: begin
            if (op_ff == OP_TICK) begin
               // a second fire row needs the output register for the one held back
               advance = !(hit_fire && can_report && (rep_ff != '0) && !out_free);
               if (advance && cur_busy) begin
                  if (hit_fire) begin
                     busy_in[idx_ff] = 1'b0;
                     if (can_report) begin
                        if (rep_ff != '0) begin
                           rsp_row_in   = pend_ff;
                           rsp_last_in  = 1'b0;
                           rsp_valid_in = 1'b1;
                        end
                        pend_in.kind     = KIND_FIRE;
                        pend_in.slot     = slot_of(idx_ff);
                        pend_in.fired_id = rd_data.owner;
                        pend_in.status   = ST_OK;
                        rep_in           = rep_ff + 1'b1;
                     end
                  end else begin
                     wr_en         = 1'b1;
                     wr_data.count = cnt_next;
                  end
               end
               if (advance && last_idx) begin
                  state_in = S_FINISH;
               end
            end else begin
               advance = 1'b1;
               if (hit_unreg) begin
                  busy_in[idx_ff] = 1'b0;
                  pend_in.slot    = slot_of(idx_ff);
                  pend_in.status  = ST_OK;
                  state_in        = S_FINISH;
               end else if (last_idx) begin
                  state_in = S_FINISH;
               end
            end
            idx_in  = advance ? idx_ff + 1'b1 : idx_ff;
            rd_addr = idx_in;
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_row_in   = pend_ff;
               rsp_last_in  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rep_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         rep_ff       <= rep_in;
      end
      op_ff       <= op_in;
      id_ff       <= id_in;
      pend_ff     <= pend_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   `OSTT_ASSERT(a_reg_claims_one, (accept && req.operation == OP_REGISTER && free_found) |=> ($countones(busy_ff) == $countones($past(busy_ff)) + 1), "register did not claim exactly one slot")
   `OSTT_ASSERT(a_scan_never_claims, (state_ff == S_SCAN) |=> ($countones(busy_ff) <= $countones($past(busy_ff))), "slot claimed during a walk")
   `OSTT_ASSERT(a_finish_to_idle, (state_ff == S_FINISH && out_free) |=> (state_ff == S_IDLE && rsp_valid_ff && rsp_last_ff), "final row not loaded on finish")
   `OSTT_ASSERT(a_report_bound, rep_ff <= REP_W'(MAX_RESULTS), "more fire rows counted than allowed")
   `OSTT_ASSERT_ALWAYS(a_reset_quiet, reset |=> (state_ff == S_IDLE && !rsp_valid_ff), "not idle after reset")

endmodule

// ----- hdl/ostt_ram.sv -----
module ostt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- test/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ostt_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 4 * SLOT_COUNT + 8;
   localparam int HOLD_CYCLES   = 400;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  id;
      logic [15:0] delay;
      bit          drain;
   } timer_item_type;

   typedef struct packed {
      row_type row;
      logic    last;
   } timer_row_type;

   logic clock;
   logic reset;

   ostt_req_if req_ch ();
   ostt_rsp_if rsp_ch ();

   one_shot_timer_table dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   timer_item_type items_waiting[$];
   timer_row_type  rows_due[$];

   bit          slot_busy[SLOT_COUNT];
   logic [7:0]  slot_owner[SLOT_COUNT];
   logic [15:0] slot_limit[SLOT_COUNT];
   logic [15:0] slot_count[SLOT_COUNT];

   int errors, rows_checked, accepted, cycles;
   int n_tick, n_reg, n_unreg, n_unused, n_fire, n_full, n_missing, most_fires;
   int gap_left, stall_left, hold_left;
   bit hold_done;

   function automatic void add_row(logic [1:0] kind, int idx, logic [7:0] id,
                                   logic [1:0] status, logic last);
      timer_row_type r;
      r.row.kind     = kind;
      r.row.slot     = idx[SLOT_W-1:0];
      r.row.fired_id = id;
      r.row.status   = status;
      r.last         = last;
      rows_due.push_back(r);
   endfunction

   // expected rows for one accepted item, state updated as the table would
   function automatic void advance_timer_table(timer_item_type it);
      int  fires;
      bit  done;
      fires = 0;
      done  = 0;
      case (it.op)
         OP_REGISTER: begin
            n_reg++;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!done && !slot_busy[i]) begin
                  slot_busy[i]  = 1'b1;
                  slot_owner[i] = it.id;
                  slot_limit[i] = it.delay;
                  slot_count[i] = 16'd0;
                  done = 1;
                  add_row(KIND_STATUS, i, 8'd0, ST_OK, 1'b1);
               end
            end
            if (!done) begin
               n_full++;
               add_row(KIND_STATUS, 0, 8'd0, ST_FULL, 1'b1);
            end
         end
         OP_UNREGISTER: begin
            n_unreg++;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!done && slot_busy[i] && slot_owner[i] == it.id) begin
                  slot_busy[i] = 1'b0;
                  done = 1;
                  add_row(KIND_STATUS, i, 8'd0, ST_OK, 1'b1);
               end
            end
            if (!done) begin
               n_missing++;
               add_row(KIND_STATUS, 0, 8'd0, ST_NOT_FOUND, 1'b1);
            end
         end
         OP_TICK: begin
            n_tick++;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slot_busy[i]) begin
                  slot_count[i] = slot_count[i] + 16'd1;
                  if (slot_count[i] == slot_limit[i]) begin
                     if (fires < MAX_RESULTS) begin
                        add_row(KIND_FIRE, i, slot_owner[i], ST_OK, 1'b0);
                        fires++;
                     end
                     slot_busy[i] = 1'b0;
                  end
               end
            end
            if (fires == 0)
               add_row(KIND_QUIET, 0, 8'd0, ST_OK, 1'b1);
            else
               rows_due[rows_due.size() - 1].last = 1'b1;
            n_fire += fires;
            if (fires > most_fires)
               most_fires = fires;
         end
         default: n_unused++;
      endcase
   endfunction

   function automatic int pick_gap(bit calm);
      int r;
      if (calm)
         return 0;
      r = $urandom_range(99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [7:0] pick_id();
      if ($urandom_range(99) < 80)
         return 8'($urandom_range(7));
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [15:0] pick_delay();
      int r;
      r = $urandom_range(99);
      if (r < 75)
         return 16'($urandom_range(8, 1));
      if (r < 85)
         return 16'($urandom_range(40, 9));
      if (r < 95)
         return 16'($urandom_range(65535));
      return 16'd0;
   endfunction

   function automatic void queue_item(logic [1:0] op, logic [7:0] id, logic [15:0] delay,
                                      bit drain);
      timer_item_type it;
      it.op    = op;
      it.id    = id;
      it.delay = delay;
      it.drain = drain;
      items_waiting.push_back(it);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.operation   = OP_TICK;
      req_ch.timer_id    = 8'd0;
      req_ch.delay_ticks = 16'd0;
      rsp_ch.ready       = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin : drive_req
      logic offer;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            advance_timer_table(items_waiting.pop_front());
            accepted++;
            gap_left = pick_gap(accepted / 40 % 3 == 1);
         end
         offer = 1'b0;
         if (gap_left > 0)
            gap_left--;
         else if (items_waiting.size() != 0 &&
                  !(items_waiting[0].drain && rows_due.size() != 0))
            offer = 1'b1;
         req_ch.valid <= offer;
         if (offer) begin
            req_ch.operation   <= items_waiting[0].op;
            req_ch.timer_id    <= items_waiting[0].id;
            req_ch.delay_ticks <= items_waiting[0].delay;
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      timer_row_type want;
      logic take;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rows_checked++;
            if (rows_due.size() == 0) begin
               errors++;
               $error("unexpected item: kind %0d slot %0d fired_id %0d status %0d",
                      rsp_ch.kind, rsp_ch.slot, rsp_ch.fired_id, rsp_ch.status);
            end else begin
               want = rows_due.pop_front();
               check_field("kind", 8'(want.row.kind), 8'(rsp_ch.kind));
               check_field("slot", 8'(want.row.slot), 8'(rsp_ch.slot));
               check_field("fired_id", want.row.fired_id, rsp_ch.fired_id);
               check_field("status", 8'(want.row.status), 8'(rsp_ch.status));
               check_field("last", 8'(want.last), 8'(rsp_ch.last));
            end
            // one long back-pressure stretch so the input stalls
            if (!hold_done && rows_checked == 150) begin
               hold_done = 1;
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            take = 1'b0;
         end else begin
            take = 1'b1;
            if (rows_checked / 60 % 3 != 2 && $urandom_range(99) < 20)
               stall_left = pick_gap(1'b0);
         end
         rsp_ch.ready <= take;
      end
   end

   initial begin : run
      int r, k, d, n_random;
      logic [15:0] dl;

      queue_item(OP_TICK, 8'h00, 16'h0000, 0);
      queue_item(OP_UNREGISTER, 8'h5A, 16'h0000, 0);
      queue_item(OP_REGISTER, 8'h00, 16'd1, 0);
      queue_item(OP_REGISTER, 8'hFF, 16'd1, 0);
      queue_item(OP_REGISTER, 8'h81, 16'd1, 0);
      queue_item(OP_REGISTER, 8'h7E, 16'd1, 0);
      queue_item(OP_REGISTER, 8'h01, 16'd1, 0);
      queue_item(OP_REGISTER, 8'h80, 16'd1, 0);
      queue_item(OP_REGISTER, 8'h00, 16'd1, 0);
      queue_item(OP_REGISTER, 8'hC3, 16'd1, 0);
      queue_item(OP_REGISTER, 8'h99, 16'hFFFF, 0);
      queue_item(OP_TICK, 8'hFF, 16'hFFFF, 0);
      queue_item(OP_UNREGISTER, 8'h00, 16'h0000, 0);
      queue_item(OP_REGISTER, 8'h3C, 16'h0000, 0);
      queue_item(OP_REGISTER, 8'hFF, 16'hFFFF, 0);
      queue_item(OP_REGISTER, 8'h3C, 16'd2, 0);
      queue_item(OP_UNREGISTER, 8'h3C, 16'h0000, 0);
      queue_item(OP_TICK, 8'h00, 16'h0000, 0);
      queue_item(OP_TICK, 8'h00, 16'h0000, 0);
      queue_item(OP_UNREGISTER, 8'hFF, 16'hFFFF, 0);
      queue_item(OP_UNUSED, 8'hFF, 16'hFFFF, 0);
      queue_item(OP_TICK, 8'h00, 16'h0000, 0);

      // sender waits here for the directed rows to drain
      queue_item(OP_TICK, 8'($urandom), 16'($urandom), 1);
      n_random = 1;
      while (n_random < 440) begin
         r = $urandom_range(99);
         if (r < 12) begin
            k = $urandom_range(SLOT_COUNT, 1);
            d = $urandom_range(5, 1);
            repeat (k) queue_item(OP_REGISTER, pick_id(), 16'(d), 0);
            repeat (d) queue_item(OP_TICK, 8'($urandom), 16'($urandom), 0);
            n_random += k + d;
         end else if (r < 40) begin
            dl = pick_delay();
            // long timers get a reusable id so a later unregister frees them
            if (dl > 16'd40 || dl == 16'd0)
               queue_item(OP_REGISTER, 8'($urandom_range(7)), dl, 0);
            else
               queue_item(OP_REGISTER, pick_id(), dl, 0);
            n_random++;
         end else if (r < 70) begin
            queue_item(OP_TICK, 8'($urandom), 16'($urandom), 0);
            n_random++;
         end else if (r < 90) begin
            queue_item(OP_UNREGISTER, pick_id(), 16'($urandom), 0);
            n_random++;
         end else if (r < 93) begin
            queue_item(OP_UNUSED, 8'($urandom), 16'($urandom), 0);
         end else if (r < 97) begin
            for (int i = 0; i < 8; i++)
               queue_item(OP_UNREGISTER, 8'(i), 16'($urandom), 0);
            n_random += 8;
         end else begin
            queue_item(OP_TICK, 8'($urandom), 16'($urandom), 1);
            n_random++;
         end
      end

      @(negedge reset);
      while (items_waiting.size() != 0 || rows_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("items sent %0d: %0d ticks, %0d registers, %0d unregisters, %0d ignored",
               accepted, n_tick, n_reg, n_unreg, n_unused);
      $display("items checked %0d: %0d fires (up to %0d per tick), %0d full, %0d not found",
               rows_checked, n_fire, most_fires, n_full, n_missing);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
